// File: sv/dss_pkg.sv
// shared types and constants of the dual stepper step generator
package dss_pkg;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned RATE_W   = 15;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned REPS_W   = 11;
	localparam int unsigned PERIOD_W = 23;

	// raw command codes on the input stream
	localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INIT      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_START     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_STOP      = 3'd5;

	// rate table
	localparam logic [RATE_W-1:0]   RATE_MAX       = 15'd20000;
	localparam logic [RATE_W-1:0]   RATE_FAST_MIN  = 15'd77;
	localparam logic [RATE_W-1:0]   RATE_LOW_MAX   = 15'd10;
	localparam logic [PERIOD_W-1:0] DIVIDEND_FAST  = 23'd4999999;
	localparam logic [PERIOD_W-1:0] DIVIDEND_SLOW  = 23'd999;
	localparam logic [PERIOD_W-1:0] PERIOD_KHZ     = 23'd4999;
	localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 23'd49999;
	localparam logic [REPS_W-1:0]   REPS_HALF_HZ   = 11'd2000;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_INITED,
		MODE_STEPPING,
		MODE_HALTED
	} mode_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_INIT,
		OP_SET,
		OP_SET_START,
		OP_START,
		OP_STOP,
		OP_ILLEGAL
	} op_t;

	// classified command as it sits in the queue
	typedef struct packed {
		op_t                op;
		logic               side;
		logic               dir;
		logic [COUNT_W-1:0] total;
		logic               total_zero;
	} entry_t;

	typedef struct packed {
		mode_t              mode;
		logic [COUNT_W-1:0] count;
		logic               dir;
		logic               phase;
		logic               step_pin;
		logic               dir_pin;
	} motor_t;

	// new prescale and period from the rate divider
	typedef struct packed {
		logic                load;
		logic [REPS_W-1:0]   reps;
		logic [PERIOD_W-1:0] period;
	} rate_upd_t;

	typedef struct packed {
		logic                status;
		logic                left_step_pin;
		logic                right_step_pin;
		logic                left_dir_pin;
		logic                right_dir_pin;
		logic                drive_enable_n;
		logic [COUNT_W-1:0]  left_remaining;
		logic [COUNT_W-1:0]  right_remaining;
		logic                left_busy;
		logic                right_busy;
		logic [PERIOD_W-1:0] timer_period;
	} result_t;

endpackage

// File: sv/dss_rate_div.sv
// bit-serial divider that turns a step rate into prescale count and timer period
module dss_rate_div
	import dss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [RATE_W-1:0] cfg_wdata,
	output logic              busy,
	output rate_upd_t         upd
);

	localparam int unsigned CNT_W = $clog2(PERIOD_W + 1);

	logic [CNT_W-1:0]    cnt_q;
	logic [RATE_W-1:0]   div_q;
	logic [RATE_W-1:0]   rem_q;
	logic [PERIOD_W-1:0] quo_q;
	logic                load_q;
	logic [REPS_W-1:0]   reps_q;
	logic [PERIOD_W-1:0] period_q;

	logic [RATE_W:0]     trial;
	logic [RATE_W:0]     diff;
	logic                ge;
	logic [PERIOD_W-1:0] quo_next;
	logic                start;

	assign start    = cfg_wen && (cfg_wdata <= RATE_MAX);
	assign trial    = {rem_q, quo_q[PERIOD_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = (trial >= {1'b0, div_q});
	assign quo_next = {quo_q[PERIOD_W-2:0], ge};
	assign busy     = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			load_q <= 1'b0;
		end else begin
			load_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(PERIOD_W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					load_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= cfg_wdata;
			rem_q <= '0;
			quo_q <= (cfg_wdata > RATE_FAST_MIN) ? DIVIDEND_FAST : DIVIDEND_SLOW;
		end else if (busy) begin
			rem_q <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
			quo_q <= quo_next;
			if (cnt_q == CNT_W'(1)) begin
				// last quotient bit lands here, pick the table row
				if (div_q == '0) begin
					reps_q   <= REPS_HALF_HZ;
					period_q <= PERIOD_KHZ;
				end else if (div_q > RATE_FAST_MIN) begin
					reps_q   <= '0;
					period_q <= quo_next;
				end else if (div_q > RATE_LOW_MAX) begin
					reps_q   <= quo_next[REPS_W-1:0];
					period_q <= PERIOD_KHZ;
				end else begin
					reps_q   <= quo_next[REPS_W-1:0] + 1'b1;
					period_q <= PERIOD_KHZ;
				end
			end
		end
	end

	assign upd.load   = load_q;
	assign upd.reps   = reps_q;
	assign upd.period = period_q;

endmodule

// File: sv/dss_front.sv
// front end: accepts commands and classifies them for the queue
module dss_front
	import dss_pkg::*;
(
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [3:0]         s_tuser,
	input  logic [39:0]        s_tdata,
	input  logic               q_full,
	input  logic               div_busy,
	output logic               push,
	output entry_t             entry
);

	logic [CMD_W-1:0] cmd;

	assign cmd      = s_tuser[CMD_W-1:0];
	assign s_tready = !q_full && !div_busy;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		unique case (cmd)
			CMD_TICK:      entry.op = OP_TICK;
			CMD_INIT:      entry.op = OP_INIT;
			CMD_SET:       entry.op = OP_SET;
			CMD_SET_START: entry.op = OP_SET_START;
			CMD_START:     entry.op = OP_START;
			CMD_STOP:      entry.op = OP_STOP;
			default:       entry.op = OP_ILLEGAL;
		endcase
	end

	assign entry.side       = s_tuser[3];
	assign entry.dir        = s_tdata[0];
	assign entry.total      = s_tdata[COUNT_W:1];
	assign entry.total_zero = (s_tdata[COUNT_W:1] == '0);

endmodule

// File: sv/dss_queue.sv
// short queue of classified commands between front and back
module dss_queue
	import dss_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: sv/dss_back.sv
// back end: motor state machines, tick prescaler and result register
module dss_back
	import dss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  entry_t    head,
	output logic      pop,
	input  rate_upd_t upd,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_res
);

	motor_t              mot_q [2];
	motor_t              mot_d [2];
	logic                en_n_q, en_n_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [TICK_W-1:0]   tick_inc;
	logic [REPS_W-1:0]   reps_q, reps_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic                status;
	logic                all_off;
	logic                out_valid_q;
	result_t             res_q;

	function automatic motor_t run_motor(motor_t m);
		motor_t r;
		logic [COUNT_W-1:0] c;
		r = m;
		c = m.count;
		if (m.mode == MODE_INITED || m.mode == MODE_HALTED) begin
			if (m.count[COUNT_W-1]) begin
				r.count = '0;
			end
		end else if (m.mode == MODE_STEPPING) begin
			// most negative count saturates
			if (m.count != {1'b1, {(COUNT_W-1){1'b0}}}) begin
				c = m.count - 1'b1;
			end
			r.count = c;
			if (c == '0 || c[COUNT_W-1]) begin
				r.mode = MODE_HALTED;
			end
			r.dir_pin  = m.dir;
			r.step_pin = !m.phase;
			r.phase    = !m.phase;
		end
		return r;
	endfunction

	assign pop      = !q_empty && (!out_valid_q || out_ready);
	assign all_off  = (mot_q[0].mode == MODE_OFF) && (mot_q[1].mode == MODE_OFF);
	assign tick_inc = tick_q + 1'b1;

	always_comb begin
		mot_d    = mot_q;
		en_n_d   = en_n_q;
		tick_d   = tick_q;
		reps_d   = reps_q;
		period_d = period_q;
		status   = STATUS_OK;
		if (upd.load) begin
			reps_d   = upd.reps;
			period_d = upd.period;
		end
		if (pop) begin
			unique case (head.op)
				OP_TICK: begin
					if (!all_off) begin
						if (tick_inc > TICK_W'(reps_q)) begin
							tick_d = '0;
							for (int i = 0; i < 2; i++) begin
								if (mot_q[i].mode == MODE_STEPPING) begin
									en_n_d = 1'b0;
								end
								mot_d[i] = run_motor(mot_q[i]);
							end
						end else begin
							tick_d = tick_inc;
						end
					end
				end
				OP_INIT: begin
					if (!all_off) begin
						status = STATUS_ERR;
					end else begin
						reps_d   = '0;
						period_d = PERIOD_DEFAULT;
						for (int i = 0; i < 2; i++) begin
							mot_d[i].count    = '0;
							mot_d[i].step_pin = 1'b1;
							mot_d[i].dir_pin  = 1'b0;
							mot_d[i].mode     = MODE_INITED;
						end
					end
				end
				OP_SET: begin
					if (mot_q[head.side].mode == MODE_OFF) begin
						status = STATUS_ERR;
					end else begin
						mot_d[head.side].dir   = head.dir;
						mot_d[head.side].count = head.total;
					end
				end
				OP_SET_START: begin
					if (mot_q[head.side].mode == MODE_OFF || head.total_zero) begin
						status = STATUS_ERR;
					end else begin
						// direction and count stick even if the start is refused because the motor is already stepping
						mot_d[head.side].dir   = head.dir;
						mot_d[head.side].count = head.total;
						if (mot_q[head.side].mode == MODE_STEPPING) begin
							status = STATUS_ERR;
						end else begin
							mot_d[head.side].mode = MODE_STEPPING;
							en_n_d = 1'b0;
						end
					end
				end
				OP_START: begin
					if (mot_q[head.side].count == '0 ||
						mot_q[head.side].mode == MODE_STEPPING) begin
						status = STATUS_ERR;
					end else begin
						mot_d[head.side].mode = MODE_STEPPING;
						en_n_d = 1'b0;
					end
				end
				OP_STOP: begin
					if (mot_q[head.side].mode == MODE_OFF ||
						mot_q[head.side].mode == MODE_HALTED) begin
						status = STATUS_ERR;
					end else begin
						mot_d[head.side].mode = MODE_HALTED;
					end
				end
				default: begin
					status = STATUS_ERR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				mot_q[i].mode     <= MODE_OFF;
				mot_q[i].count    <= '0;
				mot_q[i].dir      <= 1'b0;
				mot_q[i].phase    <= 1'b0;
				mot_q[i].step_pin <= 1'b1;
				mot_q[i].dir_pin  <= 1'b0;
			end
			en_n_q      <= 1'b1;
			tick_q      <= '0;
			reps_q      <= '0;
			period_q    <= PERIOD_DEFAULT;
			out_valid_q <= 1'b0;
		end else begin
			mot_q    <= mot_d;
			en_n_q   <= en_n_d;
			tick_q   <= tick_d;
			reps_q   <= reps_d;
			period_q <= period_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.status          <= status;
			res_q.left_step_pin   <= mot_d[0].step_pin;
			res_q.right_step_pin  <= mot_d[1].step_pin;
			res_q.left_dir_pin    <= mot_d[0].dir_pin;
			res_q.right_dir_pin   <= mot_d[1].dir_pin;
			res_q.drive_enable_n  <= en_n_d;
			res_q.left_remaining  <= mot_d[0].count;
			res_q.right_remaining <= mot_d[1].count;
			res_q.left_busy       <= (mot_d[0].mode == MODE_STEPPING);
			res_q.right_busy      <= (mot_d[1].mode == MODE_STEPPING);
			res_q.timer_period    <= period_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// drivers once enabled are never disabled again
	a_enable_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!en_n_q |=> !en_n_q)
		else $error("drive enable released");

	// a low step pin only follows the second half of a step
	a_pin_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(mot_q[0].step_pin || !mot_q[0].phase) && (mot_q[1].step_pin || !mot_q[1].phase))
		else $error("step pin and phase disagree");

	// prescaler never moves before init
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		all_off |-> (tick_q == '0))
		else $error("tick counter moved while both motors off");

	// every popped command leaves a result in the output register
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped command produced no result");

endmodule

// File: sv/dual_stepper_step_generator.sv
// top level of the dual stepper step/direction pulse generator
//
//  channel  | signals                          | contents
//  ---------+----------------------------------+-----------------------------------------
//  command  | s_tvalid s_tready s_tuser s_tdata| cmd, motor side, direction, step total
//  result   | m_tvalid m_tready m_tuser m_tdata| status, pin levels, counts, busy, period
//  config   | cfg_wen cfg_wdata                | step rate register, write only
//
// one command per cycle sustained while m_tready stays high and no rate divide runs; a command's result is
// offered once it has passed the queue and the result register, when nothing waits ahead of it in the queue
// a step rate write of at most RATE_MAX runs a bit-serial divide; s_tready stays low meanwhile
// the back end stalls only on m_tready; the front keeps taking commands until the
// queue fills or the divider runs
// arst_n resets motor modes, counts, pins, prescaler, period and the queue
module dual_stepper_step_generator
	import dss_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	// command stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [3:0]        s_tuser,   // [2:0] cmd, [3] motor_side
	input  logic [39:0]       s_tdata,   // [0] direction, [32:1] step_total, [39:33] zero
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              m_tuser,   // [0] status
	output logic [95:0]       m_tdata,   // [0] left_step_pin, [1] right_step_pin,
	                                     // [2] left_dir_pin, [3] right_dir_pin,
	                                     // [4] drive_enable_n, [36:5] left_remaining,
	                                     // [68:37] right_remaining, [69] left_busy,
	                                     // [70] right_busy, [93:71] timer_period, [95:94] zero
	// step rate register
	input  logic              cfg_wen,
	input  logic [RATE_W-1:0] cfg_wdata
);

	logic      div_busy;
	rate_upd_t upd;
	logic      push;
	entry_t    push_entry;
	logic      pop;
	entry_t    head;
	logic      q_empty;
	logic      q_full;
	result_t   res;

	// rate register write turns into prescale and period through a bit-serial divide
	dss_rate_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.busy      (div_busy),
		.upd       (upd)
	);

	// decode the incoming command
	dss_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.div_busy (div_busy),
		.push     (push),
		.entry    (push_entry)
	);

	// decouples the input transfer from result backpressure
	dss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// executes commands in order against the motor state
	dss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.upd       (upd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack the result fields, lowest first
	assign m_tuser = res.status;
	assign m_tdata = {2'b00,
	                  res.timer_period,
	                  res.right_busy,
	                  res.left_busy,
	                  res.right_remaining,
	                  res.left_remaining,
	                  res.drive_enable_n,
	                  res.right_dir_pin,
	                  res.left_dir_pin,
	                  res.right_step_pin,
	                  res.left_step_pin};

endmodule
